// ===== rtl/core/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// shared constants, control word types and the microcode table of the
// integer to ascii digit converter
// ----------------------------------------------------------------------------
package itoa_pkg;

    // width of the value port, fixed by the interface
    localparam int VALUE_W     = 32;
    // number of value bits that take part in a conversion
    localparam int VALUE_BITS  = 32;
    localparam int DEC_DIGITS  = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS  = (VALUE_BITS + 3) / 4;
    localparam int HEX_W       = 4 * HEX_DIGITS;
    localparam int DIGIT_BITS  = 4 * DEC_DIGITS;
    localparam int LEFT_BITS   = $clog2(DEC_DIGITS + 1);
    localparam int ITER_BITS   = $clog2(VALUE_BITS);
    localparam int PC_BITS     = 3;

    localparam logic [1:0] CMD_SIGNED_DEC   = 2'd0;
    localparam logic [7:0] CHAR_MINUS       = 8'h2D;
    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A     = 8'h41;

    // microcode step addresses
    localparam logic [PC_BITS-1:0] STEP_IDLE   = 3'd0;
    localparam logic [PC_BITS-1:0] STEP_BASE   = 3'd1;
    localparam logic [PC_BITS-1:0] STEP_DABBLE = 3'd2;
    localparam logic [PC_BITS-1:0] STEP_SKIP   = 3'd3;
    localparam logic [PC_BITS-1:0] STEP_SIGN_Q = 3'd4;
    localparam logic [PC_BITS-1:0] STEP_SIGN   = 3'd5;
    localparam logic [PC_BITS-1:0] STEP_EMIT   = 3'd6;
    localparam logic [PC_BITS-1:0] STEP_DONE   = 3'd7;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DABBLE,
        OP_SKIP,
        OP_PUSH_SIGN,
        OP_PUSH_DIGIT
    } t_op;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_HEX,
        COND_ITER_NZ,
        COND_LEAD_ZERO,
        COND_POSITIVE,
        COND_OUT_BUSY,
        COND_EMIT_MORE
    } t_cond;

    typedef struct packed {
        logic               ready;
        t_op                op;
        t_cond              cond;
        logic [PC_BITS-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic hex;
        logic iter_nz;
        logic lead_zero;
        logic neg;
        logic out_free;
        logic left_one;
    } t_status;

    // microcode program: a taken condition jumps to target, else next step
    function automatic t_ctl ucode(input logic [PC_BITS-1:0] pc);
        t_ctl w;
        w = '{ready: 1'b0, op: OP_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:   w = '{1'b1, OP_LOAD,       COND_NO_INPUT,  STEP_IDLE};
            STEP_BASE:   w = '{1'b0, OP_NONE,       COND_HEX,       STEP_SKIP};
            STEP_DABBLE: w = '{1'b0, OP_DABBLE,     COND_ITER_NZ,   STEP_DABBLE};
            STEP_SKIP:   w = '{1'b0, OP_SKIP,       COND_LEAD_ZERO, STEP_SKIP};
            STEP_SIGN_Q: w = '{1'b0, OP_NONE,       COND_POSITIVE,  STEP_EMIT};
            STEP_SIGN:   w = '{1'b0, OP_PUSH_SIGN,  COND_OUT_BUSY,  STEP_SIGN};
            STEP_EMIT:   w = '{1'b0, OP_PUSH_DIGIT, COND_EMIT_MORE, STEP_EMIT};
            STEP_DONE:   w = '{1'b0, OP_NONE,       COND_ALWAYS,    STEP_IDLE};
            default:     w = '{1'b0, OP_NONE,       COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

    // digit value to upper-case ascii
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_UPPER_A + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/itoa_seq.sv =====
// ----------------------------------------------------------------------------
// itoa_seq
// microcode sequencer: step counter, control table and jump condition select
// ----------------------------------------------------------------------------
module itoa_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itoa_pkg::t_status i_status,
    output itoa_pkg::t_ctl    o_ctl
);

    logic [itoa_pkg::PC_BITS-1:0] r_pc;
    logic [itoa_pkg::PC_BITS-1:0] n_pc;
    itoa_pkg::t_ctl               w_ctl;
    logic                         w_taken;

    assign w_ctl = itoa_pkg::ucode(r_pc);
    assign o_ctl = w_ctl;

    always_comb begin
        unique case (w_ctl.cond)
            itoa_pkg::COND_ALWAYS:    w_taken = 1'b1;
            itoa_pkg::COND_NO_INPUT:  w_taken = !i_status.in_valid;
            itoa_pkg::COND_HEX:       w_taken = i_status.hex;
            itoa_pkg::COND_ITER_NZ:   w_taken = i_status.iter_nz;
            itoa_pkg::COND_LEAD_ZERO: w_taken = i_status.lead_zero;
            itoa_pkg::COND_POSITIVE:  w_taken = !i_status.neg;
            itoa_pkg::COND_OUT_BUSY:  w_taken = !i_status.out_free;
            itoa_pkg::COND_EMIT_MORE: w_taken = !i_status.out_free || !i_status.left_one;
            default:                  w_taken = 1'b1;
        endcase
        n_pc = w_taken ? w_ctl.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= itoa_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/integer_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// converts a binary value to ascii digits: signed decimal, unsigned decimal
// or upper-case hexadecimal, most significant character first
// ----------------------------------------------------------------------------
// A number is taken when i_valid and o_ready are both high; its characters
// then leave one transaction at a time on o_character, with o_last high on
// the final one. A microcoded sequencer steps a small datapath: for decimal
// it runs one shift-and-add-3 (double dabble) step per cycle over all value
// bits, for hex the nibbles are loaded directly; then leading zero digits
// are dropped one per cycle, an optional '-' is sent and the digits follow
// at one per cycle while the consumer keeps i_ready high. The steps in
// order are the load step, the base check, the dabble steps for decimal,
// the leading zero drop, the sign check, the optional sign step, the digit
// output and a final step back to idle. While a character waits in the
// one-character output register, the sign and digit steps hold; after the
// last character enters that register, the sequencer passes through the
// done step and returns to idle, where the next number is taken.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_command,
    input  logic [itoa_pkg::VALUE_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_character,
    output logic                         o_last
);

    localparam int VB = itoa_pkg::VALUE_BITS;
    localparam int DB = itoa_pkg::DIGIT_BITS;

    itoa_pkg::t_ctl    w_ctl;
    itoa_pkg::t_status w_status;

    // datapath registers
    logic [VB-1:0]                  r_bin,    n_bin;
    logic [DB-1:0]                  r_digits, n_digits;
    logic [itoa_pkg::LEFT_BITS-1:0] r_left,   n_left;
    logic [itoa_pkg::ITER_BITS-1:0] r_iter,   n_iter;
    logic                           r_neg,    n_neg;
    logic                           r_hex,    n_hex;
    // output register
    logic                           r_o_valid, n_o_valid;
    logic [7:0]                     r_o_char,  n_o_char;
    logic                           r_o_last,  n_o_last;

    logic [VB-1:0]                  w_val;
    logic                           w_in_neg;
    logic [VB-1:0]                  w_mag;
    logic [itoa_pkg::HEX_W-1:0]     w_hexword;
    logic [DB-1:0]                  w_adj;
    logic [3:0]                     w_top;
    logic                           w_out_free;
    logic                           w_left_one;

    itoa_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctl    (w_ctl)
    );

    // operand as seen at load time
    assign w_val     = VB'(i_value);
    assign w_in_neg  = (i_command == itoa_pkg::CMD_SIGNED_DEC) && w_val[VB-1];
    assign w_mag     = w_in_neg ? (~w_val + 1'b1) : w_val;
    assign w_hexword = itoa_pkg::HEX_W'(w_val);

    assign w_top      = r_digits[DB-1 -: 4];
    assign w_left_one = (r_left == itoa_pkg::LEFT_BITS'(1));
    assign w_out_free = !r_o_valid || i_ready;

    assign w_status = '{
        in_valid:  i_valid,
        hex:       r_hex,
        iter_nz:   (r_iter != '0),
        lead_zero: (w_top == 4'd0) && !w_left_one,
        neg:       r_neg,
        out_free:  w_out_free,
        left_one:  w_left_one
    };

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < itoa_pkg::DEC_DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_digits[4*k +: 4] >= 4'd5) ?
                              r_digits[4*k +: 4] + 4'd3 : r_digits[4*k +: 4];
        end
    end

    always_comb begin
        n_bin     = r_bin;
        n_digits  = r_digits;
        n_left    = r_left;
        n_iter    = r_iter;
        n_neg     = r_neg;
        n_hex     = r_hex;
        n_o_valid = r_o_valid && !i_ready;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        unique case (w_ctl.op)
            itoa_pkg::OP_LOAD: begin
                if (i_valid) begin
                    n_neg  = w_in_neg;
                    n_hex  = i_command[1];
                    n_bin  = w_mag;
                    n_iter = itoa_pkg::ITER_BITS'(VB - 1);
                    if (i_command[1]) begin
                        // hex nibbles left-aligned in the digit register
                        n_digits = DB'(w_hexword) << (DB - itoa_pkg::HEX_W);
                        n_left   = itoa_pkg::LEFT_BITS'(itoa_pkg::HEX_DIGITS);
                    end else begin
                        n_digits = '0;
                        n_left   = itoa_pkg::LEFT_BITS'(itoa_pkg::DEC_DIGITS);
                    end
                end
            end
            itoa_pkg::OP_DABBLE: begin
                n_digits = {w_adj[DB-2:0], r_bin[VB-1]};
                n_bin    = r_bin << 1;
                n_iter   = r_iter - 1'b1;
            end
            itoa_pkg::OP_SKIP: begin
                if (w_top == 4'd0 && !w_left_one) begin
                    n_digits = r_digits << 4;
                    n_left   = r_left - 1'b1;
                end
            end
            itoa_pkg::OP_PUSH_SIGN: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::CHAR_MINUS;
                    n_o_last  = 1'b0;
                end
            end
            itoa_pkg::OP_PUSH_DIGIT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::digit_char(w_top);
                    n_o_last  = w_left_one;
                    n_digits  = r_digits << 4;
                    n_left    = r_left - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_left    <= '0;
            r_iter    <= '0;
            r_neg     <= 1'b0;
            r_hex     <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
            r_left    <= n_left;
            r_iter    <= n_iter;
            r_neg     <= n_neg;
            r_hex     <= n_hex;
        end
        r_bin    <= n_bin;
        r_digits <= n_digits;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    assign o_ready     = w_ctl.ready;
    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;

`ifndef NO_ASSERTIONS
    // a taken number leaves the idle step with digits to send
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> (!o_ready && r_left != '0))
        else $error("load did not start a conversion");

    // the minus sign only comes from a negative signed decimal number
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == itoa_pkg::OP_PUSH_SIGN) |-> (r_neg && !r_hex))
        else $error("minus sign for a non-negative number");

    // emitting a digit always has one left
    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == itoa_pkg::OP_PUSH_DIGIT) |-> (r_left != '0))
        else $error("digit emitted with none left");

    // final digit pushed shows up marked last
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == itoa_pkg::OP_PUSH_DIGIT && w_out_free && w_left_one)
        |=> (o_valid && o_last))
        else $error("final digit not marked last");
`endif

endmodule

// ===== verif/integer_to_ascii_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_ascii_checker
// watches both channels of the digit converter, spells each accepted number
// into the characters it must produce and compares every output transaction
// ----------------------------------------------------------------------------
module integer_to_ascii_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [itoa_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [7:0]                   i_character,
    input  logic                         i_last,
    output int                           o_pending,
    output int                           o_errors,
    output int                           o_numbers,
    output int                           o_chars
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_slot;

    t_char_slot expected_chars[$];
    t_char_slot head;

    // digit value to its ascii glyph, upper-case for ten and above
    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else begin
            c = 8'h37 + {4'd0, d};
        end
        return c;
    endfunction

    // queue the characters one number must produce, most significant first
    function automatic void spell_number(input logic [1:0] cmd,
                                         input logic [itoa_pkg::VALUE_W-1:0] value);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] base;
        logic [3:0]  rev [24];
        logic        neg;
        int          nd;
        mask = (64'd1 << itoa_pkg::VALUE_BITS) - 64'd1;
        mag  = 64'(value) & mask;
        base = cmd[1] ? 64'd16 : 64'd10;
        neg  = 1'b0;
        nd   = 0;
        if (cmd == itoa_pkg::CMD_SIGNED_DEC && mag[itoa_pkg::VALUE_BITS-1]) begin
            neg = 1'b1;
            mag = (~mag + 64'd1) & mask;
        end
        do begin
            rev[nd] = 4'(mag % base);
            mag = mag / base;
            nd++;
        end while (mag != 0 && nd < 24);
        if (neg) begin
            expected_chars.push_back('{ch: itoa_pkg::CHAR_MINUS, last: 1'b0});
        end
        for (int i = nd - 1; i >= 0; i--) begin
            expected_chars.push_back('{ch: glyph(rev[i]), last: (i == 0)});
        end
    endfunction

    initial begin
        o_pending = 0;
        o_errors  = 0;
        o_numbers = 0;
        o_chars   = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // older numbers drain first, so check before queueing a new one
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected character: expected none, got %h last %b",
                             $time, i_character, i_last);
                end else begin
                    head = expected_chars.pop_front();
                    o_chars++;
                    if (i_character !== head.ch) begin
                        o_errors++;
                        $display("%0t: character mismatch: expected %h, got %h",
                                 $time, head.ch, i_character);
                    end
                    if (i_last !== head.last) begin
                        o_errors++;
                        $display("%0t: last flag mismatch: expected %b, got %b",
                                 $time, head.last, i_last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                spell_number(i_command, i_value);
                o_numbers++;
            end
            o_pending = expected_chars.size();
        end
    end

endmodule

// ===== verif/tb_integer_to_ascii_digits.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits
// drives numbers into the digit converter under random handshake gaps and
// stalls; a checker beside the block predicts and compares every character
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_digits;

    // command codes beyond the one the package names; code three aliases hex
    localparam logic [1:0] CMD_UNSIGNED_DEC = 2'd1;
    localparam logic [1:0] CMD_HEX          = 2'd2;
    localparam logic [1:0] CMD_HEX_ALIAS    = 2'd3;

    localparam int RANDOM_NUMBERS = 288;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [1:0]                   i_command;
    logic [itoa_pkg::VALUE_W-1:0] i_value;
    logic                         o_valid;
    logic                         i_ready;
    logic [7:0]                   o_character;
    logic                         o_last;

    int                   pending;
    int                   errors;
    int                   numbers;
    int                   chars;

    // when set, neither side idles: back-to-back numbers and characters
    logic                 steady;

    integer_to_ascii_digits u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    integer_to_ascii_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_character (o_character),
        .i_last      (o_last),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_numbers   (numbers),
        .o_chars     (chars)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // hard stop well past the slowest legal run
    initial begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one number: optional gap, then hold valid until the block takes it;
    // starts and ends at a falling edge
    task automatic send_number(input logic [1:0] cmd,
                               input logic [itoa_pkg::VALUE_W-1:0] val);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command <= cmd;
        i_value   <= val;
        i_valid   <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every predicted character has come out
    task automatic drain_numbers;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // receiver: a random stall before each character, ready held otherwise
    initial begin : char_sink
        int stall;
        i_ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) begin
            @(negedge i_clk);
        end
        forever begin
            stall = steady ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!o_valid);
            @(negedge i_clk);
        end
    end

    initial begin : number_source
        logic [1:0]                   cmd;
        logic [itoa_pkg::VALUE_W-1:0] val;
        int unsigned                  pow;
        int                           pick;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_command = itoa_pkg::CMD_SIGNED_DEC;
        i_value   = '0;
        steady    = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero, one, range ends, most negative value, hex alias
        send_number(itoa_pkg::CMD_SIGNED_DEC, 32'h0000_0000);
        send_number(itoa_pkg::CMD_SIGNED_DEC, 32'h0000_0001);
        send_number(itoa_pkg::CMD_SIGNED_DEC, 32'h7FFF_FFFF);
        send_number(itoa_pkg::CMD_SIGNED_DEC, 32'h8000_0000);
        send_number(itoa_pkg::CMD_SIGNED_DEC, 32'hFFFF_FFFF);
        send_number(itoa_pkg::CMD_SIGNED_DEC, 32'hFFFF_FFF6);
        send_number(itoa_pkg::CMD_SIGNED_DEC, 32'd1000000000);
        send_number(CMD_UNSIGNED_DEC, 32'h0000_0000);
        send_number(CMD_UNSIGNED_DEC, 32'd9);
        send_number(CMD_UNSIGNED_DEC, 32'd10);
        send_number(CMD_UNSIGNED_DEC, 32'hFFFF_FFFF);
        send_number(CMD_UNSIGNED_DEC, 32'h8000_0000);
        send_number(CMD_UNSIGNED_DEC, 32'd4000000000);
        send_number(CMD_HEX,          32'h0000_0000);
        send_number(CMD_HEX,          32'h0000_000F);
        send_number(CMD_HEX,          32'h0000_0010);
        send_number(CMD_HEX,          32'hFFFF_FFFF);
        send_number(CMD_HEX,          32'h1234_5678);
        send_number(CMD_HEX,          32'h0ABC_DEF0);
        send_number(CMD_HEX_ALIAS,    32'h0000_0000);
        send_number(CMD_HEX_ALIAS,    32'hFFFF_FFFF);
        send_number(CMD_HEX_ALIAS,    32'h89AB_CDEF);

        // hold off until the directed numbers are fully out
        drain_numbers();

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            // every third block of 40 numbers runs with no random gaps or stalls
            steady <= ((n / 40) % 3 == 2);
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                cmd = itoa_pkg::CMD_SIGNED_DEC;
            end else if (pick < 6) begin
                cmd = CMD_UNSIGNED_DEC;
            end else if (pick < 9) begin
                cmd = CMD_HEX;
            end else begin
                cmd = CMD_HEX_ALIAS;
            end
            case ($urandom_range(0, 5))
                0: val = $urandom;
                1: val = $urandom_range(0, 20);
                2: begin
                    // around a power of ten, where digit counts change
                    pow = 1;
                    repeat ($urandom_range(0, 9)) pow = pow * 10;
                    val = pow + $urandom_range(0, 2) - 1;
                end
                3: val = (32'd1 << (4 * $urandom_range(0, 7))) - $urandom_range(0, 1);
                4: val = -($urandom_range(1, 1000));
                default: val = $urandom >> $urandom_range(0, 31);
            endcase
            send_number(cmd, val);
            // now and then let the block run dry between numbers
            if (n % 70 == 69) begin
                drain_numbers();
            end
        end

        steady <= 1'b0;
        drain_numbers();
        repeat (80) @(negedge i_clk);

        $display("covered %0d numbers in signed, unsigned and hex form, incl. the hex alias",
                 numbers);
        $display("checked %0d characters under random gaps, stalls and back-to-back bursts",
                 chars);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
